// ===== src/cmf_pkg.sv =====
// Shared types and constants of the chroma median filter.
`default_nettype none

package cmf_pkg;

  localparam int CFG_W   = 13;
  localparam int RAD_W   = 2;
  localparam int PIX_W   = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int GAP_W   = 26;
  localparam int FIFO_D  = 16;
  localparam int FIFO_AW = 4;
  localparam int GRP     = 8;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1080;
  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] u;
  } cmf_pix_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic done;
  } cmf_ctl_t;

  typedef struct packed {
    logic     done;
    cmf_pix_t pix;
  } cmf_out_t;

  typedef struct packed {
    logic             hit;
    logic [PIX_W-1:0] val;
  } cmf_hit_t;

endpackage

`default_nettype wire

// ===== src/chroma_median_filter.sv =====
// Top level of the chroma median filter: line store, window, lanes and result queue.
// Throughput is one request per cycle while in_stall is low; a window result reaches
// the head of the queue, at the earliest, after the RAM read, the window shift and the
// three ranking stages plus the merge that follow the request that completes it. in_stall rises when queued and
// in-flight results reach sixteen. rst_n clears the counters and the result queue and
// loads the registers with 1920, 1080 and 1; the line store is not cleared.
`default_nettype none

module chroma_median_filter
  import cmf_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_action,
  input  wire logic [PIX_W-1:0]   in_u_in,
  input  wire logic [PIX_W-1:0]   in_v_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [PIX_W-1:0]   out_u_out,
  output logic      [PIX_W-1:0]   out_v_out,
  output logic                    out_frame_done,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int ROWS = 2 * MAX_RADIUS + 1;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int MW   = $clog2(ROWS);
  localparam int N    = ROWS * ROWS;
  localparam int RKW  = $clog2(N);
  localparam int PD   = 6;
  localparam int PW   = $clog2(FIFO_D + PD + 1);
  localparam logic [CFG_W:0] WMAX = (CFG_W+1)'(MAX_WIDTH);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [RAD_W-1:0] radius_r;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic             restart;

  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [RAD_W-1:0] r_eff;
  logic [CFG_W+1:0] rw;
  logic [GAP_W-1:0] lag;
  logic [5:0]       kk;
  logic [RKW-1:0]   k;

  logic [CFG_W-1:0] icol_r, icol_nxt, irow_r, irow_nxt;
  logic [CFG_W-1:0] ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic [MW-1:0]    imod_r, imod_nxt, omod_r, omod_nxt;
  logic             in_done_r, in_done_nxt;
  logic [GAP_W-1:0] gap_r, gap_nxt, gap_a;

  logic             acc, wr, col_wrap, row_last, in_done_a, emit, out_last, interior;
  logic [CFG_W:0]   ocol_hi, orow_hi;
  cmf_pix_t         wpix;

  logic [2*PIX_W-1:0] rd_a [ROWS];
  logic [2*PIX_W-1:0] rd_b [ROWS];

  logic             p1_wr_r;
  logic             p1_byp_r;
  cmf_pix_t         p1_pix_r;
  logic [MW-1:0]    p1_wmod_r, p1_omod_r;
  logic [MW-1:0]    sel [ROWS];
  cmf_pix_t         col [ROWS];
  cmf_pix_t         copy_pix;
  cmf_pix_t         win_r [ROWS][ROWS];

  logic [PIX_W-1:0] u_vals [N];
  logic [PIX_W-1:0] v_vals [N];
  logic [N-1:0]     act;
  logic [PIX_W-1:0] med_u, med_v;

  cmf_ctl_t         ctl0;
  cmf_ctl_t         pctl_r [PD];
  cmf_pix_t         pcopy_r [PD-1];

  cmf_out_t         fifo_r [FIFO_D];
  cmf_out_t         push_data, head;
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_AW:0] cnt_r, cnt_nxt;
  logic             push, pop;
  logic [PW-1:0]    inflight, pending;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign restart = cfg_we &&
                   (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT || cfg_idx == REG_RADIUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        REG_RADIUS: radius_r <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = PDATA_W'(width_r);
      REG_HEIGHT: prdata = PDATA_W'(height_r);
      REG_RADIUS: prdata = PDATA_W'(radius_r);
      default:    prdata = '0;
    endcase
  end

  // Effective frame geometry
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if ({1'b0, width_r} > WMAX) begin
      w_eff = WMAX[CFG_W-1:0];
    end
    h_eff = (height_r == '0) ? CFG_W'(1) : height_r;
    r_eff = radius_r;
    if (radius_r == '0) begin
      r_eff = RAD_W'(1);
    end else if (int'(radius_r) > MAX_RADIUS) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end
  end

  assign rw  = (r_eff[0] ? {2'b00, w_eff} : '0) + (r_eff[1] ? {1'b0, w_eff, 1'b0} : '0);
  assign lag = GAP_W'(rw) + GAP_W'(r_eff) + GAP_W'(1);
  assign kk  = ({4'b0, r_eff} * ({4'b0, r_eff} + 6'd1)) << 1;
  assign k   = RKW'(kk);

  // Position counters
  assign acc       = in_valid & ~in_stall;
  assign wr        = acc & ~in_action & ~in_done_r;
  assign col_wrap  = (icol_r + CFG_W'(1)) == w_eff;
  assign row_last  = (irow_r + CFG_W'(1)) == h_eff;
  assign in_done_a = in_done_r | (wr & col_wrap & row_last);
  assign gap_a     = gap_r + GAP_W'(wr);
  assign emit      = acc & (in_done_a | (gap_a >= lag));
  assign out_last  = ((ocol_r + CFG_W'(1)) == w_eff) && ((orow_r + CFG_W'(1)) == h_eff);
  assign ocol_hi   = {1'b0, ocol_r} + (CFG_W+1)'(r_eff);
  assign orow_hi   = {1'b0, orow_r} + (CFG_W+1)'(r_eff);
  assign interior  = (ocol_r >= CFG_W'(r_eff)) && (ocol_hi < {1'b0, w_eff}) &&
                     (orow_r >= CFG_W'(r_eff)) && (orow_hi < {1'b0, h_eff});

  always_comb begin
    icol_nxt    = icol_r;
    irow_nxt    = irow_r;
    imod_nxt    = imod_r;
    in_done_nxt = in_done_r;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    omod_nxt    = omod_r;
    gap_nxt     = gap_r;
    if (restart) begin
      icol_nxt    = '0;
      irow_nxt    = '0;
      imod_nxt    = '0;
      in_done_nxt = 1'b0;
      ocol_nxt    = '0;
      orow_nxt    = '0;
      omod_nxt    = '0;
      gap_nxt     = '0;
    end else begin
      if (wr) begin
        if (col_wrap) begin
          icol_nxt    = '0;
          irow_nxt    = irow_r + CFG_W'(1);
          imod_nxt    = (imod_r == MW'(ROWS - 1)) ? '0 : imod_r + MW'(1);
          in_done_nxt = row_last;
        end else begin
          icol_nxt = icol_r + CFG_W'(1);
        end
      end
      gap_nxt = gap_a;
      if (emit) begin
        if (out_last) begin
          icol_nxt    = '0;
          irow_nxt    = '0;
          imod_nxt    = '0;
          in_done_nxt = 1'b0;
          ocol_nxt    = '0;
          orow_nxt    = '0;
          omod_nxt    = '0;
          gap_nxt     = '0;
        end else begin
          gap_nxt = gap_a - GAP_W'(1);
          if ((ocol_r + CFG_W'(1)) == w_eff) begin
            ocol_nxt = '0;
            orow_nxt = orow_r + CFG_W'(1);
            omod_nxt = (omod_r == MW'(ROWS - 1)) ? '0 : omod_r + MW'(1);
          end else begin
            ocol_nxt = ocol_r + CFG_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r    <= '0;
      irow_r    <= '0;
      imod_r    <= '0;
      in_done_r <= 1'b0;
      ocol_r    <= '0;
      orow_r    <= '0;
      omod_r    <= '0;
      gap_r     <= '0;
    end else begin
      icol_r    <= icol_nxt;
      irow_r    <= irow_nxt;
      imod_r    <= imod_nxt;
      in_done_r <= in_done_nxt;
      ocol_r    <= ocol_nxt;
      orow_r    <= orow_nxt;
      omod_r    <= omod_nxt;
      gap_r     <= gap_nxt;
    end
  end

  // Line store, one RAM per buffered row
  assign wpix = '{v: in_v_in, u: in_u_in};

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    cmf_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk     (clk),
      .we      (wr && (imod_r == MW'(r))),
      .waddr   (icol_r[AW-1:0]),
      .wdata   (wpix),
      .raddr_a (icol_r[AW-1:0]),
      .raddr_b (ocol_r[AW-1:0]),
      .rdata_a (rd_a[r]),
      .rdata_b (rd_b[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_wr_r <= 1'b0;
    end else begin
      p1_wr_r <= wr;
    end
    p1_pix_r  <= wpix;
    p1_wmod_r <= imod_r;
    p1_omod_r <= omod_r;
    p1_byp_r  <= wr && (imod_r == omod_r) && (icol_r == ocol_r);
  end

  // Column assembly and window shift
  always_comb begin
    col[0] = p1_pix_r;
    sel[0] = p1_wmod_r;
    for (int a = 1; a < ROWS; a++) begin
      sel[a] = (p1_wmod_r >= MW'(a)) ? p1_wmod_r - MW'(a) : p1_wmod_r + MW'(ROWS - a);
      col[a] = rd_a[sel[a]];
    end
    copy_pix = p1_byp_r ? p1_pix_r : cmf_pix_t'(rd_b[p1_omod_r]);
  end

  always_ff @(posedge clk) begin
    if (p1_wr_r) begin
      for (int a = 0; a < ROWS; a++) begin
        win_r[0][a] <= col[a];
      end
      for (int c = 1; c < ROWS; c++) begin
        for (int a = 0; a < ROWS; a++) begin
          win_r[c][a] <= win_r[c-1][a];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < ROWS; c++) begin
      for (int a = 0; a < ROWS; a++) begin
        u_vals[c*ROWS+a] = win_r[c][a].u;
        v_vals[c*ROWS+a] = win_r[c][a].v;
        act[c*ROWS+a]    = (c <= 2 * int'(r_eff)) && (a <= 2 * int'(r_eff));
      end
    end
  end

  cmf_median #(.N(N), .RKW(RKW)) u_med_u (
    .clk  (clk),
    .vals (u_vals),
    .act  (act),
    .k    (k),
    .med  (med_u)
  );

  cmf_median #(.N(N), .RKW(RKW)) u_med_v (
    .clk  (clk),
    .vals (v_vals),
    .act  (act),
    .k    (k),
    .med  (med_v)
  );

  // Control pipeline alongside the data path
  assign ctl0 = '{emit: emit, interior: interior, done: emit & out_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PD; i++) begin
        pctl_r[i] <= '0;
      end
    end else begin
      pctl_r[0] <= ctl0;
      for (int i = 1; i < PD; i++) begin
        pctl_r[i] <= pctl_r[i-1];
      end
    end
    pcopy_r[0] <= copy_pix;
    for (int i = 1; i < PD - 1; i++) begin
      pcopy_r[i] <= pcopy_r[i-1];
    end
  end

  // Result queue
  assign push      = pctl_r[PD-1].emit;
  assign push_data = '{done: pctl_r[PD-1].done,
                       pix: (pctl_r[PD-1].interior ? cmf_pix_t'({med_v, med_u})
                                                   : pcopy_r[PD-2])};
  assign head      = fifo_r[rptr_r];
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & ~out_stall;

  assign out_u_out      = head.pix.u;
  assign out_v_out      = head.pix.v;
  assign out_frame_done = head.done;

  always_comb begin
    inflight = '0;
    for (int i = 0; i < PD; i++) begin
      inflight = inflight + PW'(pctl_r[i].emit);
    end
    pending  = PW'(cnt_r) + inflight;
    in_stall = (pending >= PW'(FIFO_D));
    cnt_nxt  = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wptr_r] <= push_data;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_D))
    else $error("result queue holds more entries than its depth");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_last) |=> (ocol_r == '0 && orow_r == '0 && gap_r == '0 && !in_done_r))
    else $error("counters not cleared after the last result of a frame");

  a_input_done_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_done_r |-> (icol_r == '0))
    else $error("input column not at zero once the frame has fully arrived");

  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + (FIFO_AW+1)'(1)))
    else $error("result lost on entry to the queue");

endmodule

`default_nettype wire

// ===== src/cmf_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module cmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_a_r <= mem_r[raddr_a];
    rd_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

`default_nettype wire

// ===== src/cmf_lane.sv =====
// One ranking lane: counts the window samples below its own and flags the median.
`default_nettype none

module cmf_lane
  import cmf_pkg::*;
#(
  parameter int N   = 49,
  parameter int IDX = 0,
  parameter int RKW = 6
) (
  input  wire logic             clk,
  input  wire logic [PIX_W-1:0] vals [N],
  input  wire logic [N-1:0]     act,
  input  wire logic [RKW-1:0]   k,
  output cmf_hit_t              hit_o
);

  localparam int G  = (N + GRP - 1) / GRP;
  localparam int CW = $clog2(GRP + 1);

  logic [N-1:0]       lt;
  logic [N-1:0]       lt_r;
  logic [G*GRP-1:0]   lt_pad;
  logic [PIX_W-1:0]   val_a_r;
  logic [PIX_W-1:0]   val_b_r;
  logic               act_a_r;
  logic               act_b_r;
  logic [CW-1:0]      grp_nxt [G];
  logic [CW-1:0]      grp_r [G];
  logic [RKW:0]       sum;
  cmf_hit_t           hit_r;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      lt[j] = act[j] && ((vals[j] < vals[IDX]) || ((vals[j] == vals[IDX]) && (j < IDX)));
    end
  end

  always_comb begin
    lt_pad = '0;
    lt_pad[N-1:0] = lt_r;
    for (int g = 0; g < G; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        grp_nxt[g] = grp_nxt[g] + CW'(lt_pad[g*GRP+b]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < G; g++) begin
      sum = sum + (RKW+1)'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    lt_r    <= lt;
    val_a_r <= vals[IDX];
    act_a_r <= act[IDX];
    for (int g = 0; g < G; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
    val_b_r   <= val_a_r;
    act_b_r   <= act_a_r;
    hit_r.hit <= act_b_r && (sum == {1'b0, k});
    hit_r.val <= val_b_r;
  end

  assign hit_o = hit_r;

endmodule

`default_nettype wire

// ===== src/cmf_median.sv =====
// Median of one chroma plane: ranking lanes side by side and a merging stage.
`default_nettype none

module cmf_median
  import cmf_pkg::*;
#(
  parameter int N   = 49,
  parameter int RKW = 6
) (
  input  wire logic             clk,
  input  wire logic [PIX_W-1:0] vals [N],
  input  wire logic [N-1:0]     act,
  input  wire logic [RKW-1:0]   k,
  output logic      [PIX_W-1:0] med
);

  cmf_hit_t         lane_o [N];
  logic [PIX_W-1:0] merged;
  logic [PIX_W-1:0] med_r;

  for (genvar i = 0; i < N; i++) begin : g_lane
    cmf_lane #(.N(N), .IDX(i), .RKW(RKW)) u_lane (
      .clk   (clk),
      .vals  (vals),
      .act   (act),
      .k     (k),
      .hit_o (lane_o[i])
    );
  end

  always_comb begin
    merged = '0;
    for (int i = 0; i < N; i++) begin
      merged = merged | (lane_o[i].hit ? lane_o[i].val : '0);
    end
  end

  always_ff @(posedge clk) begin
    med_r <= merged;
  end

  assign med = med_r;

endmodule

`default_nettype wire
